// ----- src/usmb_pkg.sv -----
// Package for the 5x5 box unsharp-mask core: sizes, constants, types and states.
// Used by the RAM-free cell, the line RAM wrapper users and the top level.
package usmb_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int KERNEL = 5;
   localparam int LINES = KERNEL - 1;
   localparam int PIX_W = 8;

   // Fixed-point constants of the output formula
   localparam int SCALE = 6400;           // 256 * 25
   localparam int AREA = 25;
   localparam int RECIP = 10486;          // ceil(2^18 / 25)
   localparam int RECIP_SHIFT = 18;
   localparam int SAT_LIMIT = 256 * SCALE;

   // Register indexes of the write port
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_GAIN   = 2'd2;

   typedef logic [KERNEL-1:0][PIX_W-1:0] col_type;

   typedef struct packed {
      logic               shift;
      logic [KERNEL-1:0]  row_mask;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SHIFT,
      S_COLSUM,
      S_SUM,
      S_MUL,
      S_DIV,
      S_OUT
   } state_type;

endpackage

// ----- src/unsharp_mask_5x5_box_core.sv -----
// Top level of the 5x5 box unsharp-mask core: control, line RAM, window
// cells and output arithmetic. Depends on usmb_pkg, usmb_ram and usmb_cell.
//
//   channel | ports                               | direction
//   req     | req_valid req_ready req_sample req_drain | in
//   rsp     | rsp_valid rsp_ready rsp_out_sample rsp_frame_done | out
//   csr     | csr_wr_en csr_index csr_wdata       | in
//
// Steps per word, run one after another: line RAM read, window shift, and
// for a word that yields a result also column sums, window sum, gain
// multiply, scaling and the reciprocal divide by 25.
// Reset is synchronous; it clears the sequencer and frame counters, the
// line RAM and window hold stale data that the edge masks hide.
// A stalled rsp holds the sequencer in its last step; req is not taken then.
module unsharp_mask_5x5_box_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_sample,
   input  logic        req_drain,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_sample,
   output logic        rsp_frame_done,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int CW = usmb_pkg::COL_W;
   localparam int KN = usmb_pkg::KERNEL;
   localparam int LW = usmb_pkg::LINES * usmb_pkg::PIX_W;

   usmb_pkg::state_type state_ff, state_in;

   logic [10:0]        width_ff;
   logic [12:0]        height_ff;
   logic signed [11:0] gain_ff;

   logic [10:0] w_eff;
   logic [12:0] h_eff;
   logic [11:0] lag;

   logic [CW-1:0] in_col_ff;
   logic [11:0]   cnt_ff;
   logic          primed_ff;
   logic [CW-1:0] out_col_ff;
   logic [11:0]   out_row_ff;
   logic [CW-1:0] cur_col_ff;
   logic [11:0]   cur_row_ff;
   logic          emit_ff;
   logic          done_ff;
   logic [7:0]    pix_ff;

   logic restart;
   logic accept;
   logic emit;
   logic done;
   logic out_load;

   logic [LW-1:0] lb_rd;
   logic [LW-1:0] lb_wr;

   usmb_pkg::cell_ctrl_type ctrl;
   logic                    win_shift;
   logic [KN-1:0]           row_mask;
   usmb_pkg::col_type       chain [KN+1];
   logic [10:0]             col_sum [KN];
   logic [KN-1:0]           col_mask;

   logic [12:0]        total;
   logic [12:0]        x25;
   logic signed [13:0] d_in, d_ff;
   logic [7:0]         x_ff;
   logic signed [25:0] prod_ff;
   logic [20:0]        xs_ff;
   logic signed [27:0] num;
   logic [12:0]        q0_ff;
   logic               lo_ff, hi_ff;
   logic [26:0]        recip;
   logic [7:0]         res;

   logic       rsp_valid_ff;
   logic [7:0] rsp_sample_ff;
   logic       rsp_done_ff;

   // Effective frame size and output lag
   always_comb begin
      if (width_ff == 11'd0) begin
         w_eff = 11'd1;
      end else if (width_ff > 11'(usmb_pkg::MAX_WIDTH)) begin
         w_eff = 11'(usmb_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == 13'd0) ? 13'd1 : height_ff;
      lag = {w_eff, 1'b0} + 12'd3;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd640;
         height_ff <= 13'd480;
         gain_ff <= 12'sd256;
      end else if (csr_wr_en) begin
         case (csr_index)
            usmb_pkg::REG_WIDTH:  width_ff <= csr_wdata[10:0];
            usmb_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            usmb_pkg::REG_GAIN:   gain_ff <= $signed(csr_wdata[11:0]);
            default: ;
         endcase
      end
   end

   assign restart = csr_wr_en &&
      (csr_index == usmb_pkg::REG_WIDTH || csr_index == usmb_pkg::REG_HEIGHT);

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= usmb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and step strobes
   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      win_shift = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         usmb_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = usmb_pkg::S_READ;
            end
         end
         usmb_pkg::S_READ: state_in = usmb_pkg::S_SHIFT;
         usmb_pkg::S_SHIFT: begin
            win_shift = 1'b1;
            state_in = emit ? usmb_pkg::S_COLSUM : usmb_pkg::S_IDLE;
         end
         usmb_pkg::S_COLSUM: state_in = usmb_pkg::S_SUM;
         usmb_pkg::S_SUM:    state_in = usmb_pkg::S_MUL;
         usmb_pkg::S_MUL:    state_in = usmb_pkg::S_DIV;
         usmb_pkg::S_DIV:    state_in = usmb_pkg::S_OUT;
         usmb_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = usmb_pkg::S_IDLE;
            end
         end
         default: state_in = usmb_pkg::S_IDLE;
      endcase
   end

   assign ctrl = {win_shift, row_mask};

   assign accept = req_valid && req_ready;
   assign emit = primed_ff || (cnt_ff == lag - 12'd1);
   assign done = (13'(out_row_ff) == h_eff - 13'd1) && (11'(out_col_ff) == w_eff - 11'd1);

   // Latch the incoming word; a drain counts as a zero pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff <= req_drain ? 8'd0 : req_sample;
      end
   end

   // Frame counters: advance on the window shift, restart at frame end or on a size write
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff <= '0;
         cnt_ff <= '0;
         primed_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (ctrl.shift) begin
         if (emit && done) begin
            in_col_ff <= '0;
            cnt_ff <= '0;
            primed_ff <= 1'b0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            if (11'(in_col_ff) + 11'd1 >= w_eff) begin
               in_col_ff <= '0;
            end else begin
               in_col_ff <= in_col_ff + CW'(1);
            end
            if (!primed_ff) begin
               cnt_ff <= cnt_ff + 12'd1;
               primed_ff <= emit;
            end
            if (emit) begin
               if (11'(out_col_ff) + 11'd1 >= w_eff) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + 12'd1;
               end else begin
                  out_col_ff <= out_col_ff + CW'(1);
               end
            end
         end
      end
   end

   // Snapshot of the output position for this word
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
      end else if (ctrl.shift) begin
         emit_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         cur_col_ff <= out_col_ff;
         cur_row_ff <= out_row_ff;
         done_ff <= done;
      end
   end

   // Line RAM: four previous rows packed in one word per column
   assign lb_wr = {lb_rd[LW-9:0], pix_ff};

   usmb_ram #(
      .WIDTH(LW),
      .DEPTH(usmb_pkg::MAX_WIDTH)
   ) u_lines (
      .clock(clock),
      .wr_en(ctrl.shift),
      .wr_addr(in_col_ff),
      .wr_data(lb_wr),
      .rd_en(accept),
      .rd_addr(in_col_ff),
      .rd_data(lb_rd)
   );

   // Row and column masks for the window around the current output pixel
   always_comb begin
      row_mask[0] = cur_row_ff >= 12'd2;
      row_mask[1] = cur_row_ff >= 12'd1;
      row_mask[2] = 1'b1;
      row_mask[3] = 13'(cur_row_ff) + 13'd1 < h_eff;
      row_mask[4] = 13'(cur_row_ff) + 13'd2 < h_eff;
      col_mask[0] = 11'(cur_col_ff) + 11'd2 < w_eff;
      col_mask[1] = 11'(cur_col_ff) + 11'd1 < w_eff;
      col_mask[2] = 1'b1;
      col_mask[3] = cur_col_ff >= CW'(1);
      col_mask[4] = cur_col_ff >= CW'(2);
   end

   // Newest column: oldest row first, incoming pixel last
   assign chain[0] = {pix_ff, lb_rd[7:0], lb_rd[15:8], lb_rd[23:16], lb_rd[31:24]};

   for (genvar j = 0; j < KN; j++) begin : g_cells
      usmb_cell u_cell (
         .clock(clock),
         .ctrl(ctrl),
         .col_in(chain[j]),
         .col_out(chain[j+1]),
         .col_sum(col_sum[j])
      );
   end

   // Window sum and difference to the scaled center
   always_comb begin
      total = '0;
      for (int j = 0; j < KN; j++) begin
         if (col_mask[j]) begin
            total = total + 13'(col_sum[j]);
         end
      end
      x25 = 13'(chain[3][2]) * 13'(usmb_pkg::AREA);
      d_in = $signed({1'b0, x25}) - $signed({1'b0, total});
   end

   always_ff @(posedge clock) begin
      if (state_ff == usmb_pkg::S_SUM) begin
         d_ff <= d_in;
         x_ff <= chain[3][2];
      end
   end

   // Gain product and scaled center
   always_ff @(posedge clock) begin
      if (state_ff == usmb_pkg::S_MUL) begin
         prod_ff <= 26'(gain_ff) * 26'(d_ff);
         xs_ff <= 21'(x_ff) * 21'(usmb_pkg::SCALE);
      end
   end

   // Sum, clamp and divide by 256
   assign num = 28'(prod_ff) + $signed({7'd0, xs_ff});

   always_ff @(posedge clock) begin
      if (state_ff == usmb_pkg::S_DIV) begin
         lo_ff <= num < 28'sd0;
         hi_ff <= num >= 28'(usmb_pkg::SAT_LIMIT);
         q0_ff <= num[20:8];
      end
   end

   // Divide by 25 through the reciprocal
   assign recip = 27'(q0_ff) * 27'(usmb_pkg::RECIP);

   always_comb begin
      if (lo_ff) begin
         res = 8'd0;
      end else if (hi_ff) begin
         res = 8'd255;
      end else begin
         res = recip[usmb_pkg::RECIP_SHIFT +: 8];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= res;
         rsp_done_ff <= done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_frame_done = rsp_done_ff;

   // Checks
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second word taken while one is in flight");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      11'(in_col_ff) < w_eff)
      else $error("input column beyond frame width");

   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      out_load |-> emit_ff)
      else $error("result loaded for a word without output");

endmodule

// ----- src/usmb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module usmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/usmb_cell.sv -----
// One window column cell: holds five vertical pixels, passes them on when
// the window shifts and keeps a registered row-masked column sum.
// Depends on usmb_pkg.
module usmb_cell (
   input  logic                   clock,
   input  usmb_pkg::cell_ctrl_type ctrl,
   input  usmb_pkg::col_type      col_in,
   output usmb_pkg::col_type      col_out,
   output logic [10:0]            col_sum
);

   usmb_pkg::col_type pix_ff;
   logic [10:0] sum_ff;
   logic [10:0] sum_in;

   // Take the neighbor's column on a shift
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         pix_ff <= col_in;
      end
   end

   // Drop rows outside the frame and add the rest
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < usmb_pkg::KERNEL; k++) begin
         if (ctrl.row_mask[k]) begin
            sum_in = sum_in + 11'(pix_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign col_out = pix_ff;
   assign col_sum = sum_ff;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for unsharp_mask_5x5_box_core: a sharpening predictor,
// a queued driver and a checking monitor. Depends on usmb_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam int RING = 4 * usmb_pkg::MAX_WIDTH + 8;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [7:0] sample;
      logic       drain;
   } pixel_word_type;

   typedef struct {
      logic [7:0] out_sample;
      logic       frame_done;
   } sharp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_sample = '0;
   logic        req_drain = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_sample;
   logic        rsp_frame_done;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = usmb_pkg::REG_WIDTH;
   logic [12:0] csr_wdata = '0;

   unsharp_mask_5x5_box_core uut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [7:0]   pix_ring [RING];
   int unsigned  cfg_width, cfg_height;
   logic [11:0]  cfg_gain;
   int unsigned  fed_count, next_row, next_col;

   pixel_word_type pending_words[$];
   sharp_word_type expected_pixels[$];
   int           mismatches = 0;
   int           words_sent = 0;
   int           results_seen = 0;
   int           frames_done = 0;
   bit           stim_done = 0;
   bit           pause_req = 0;

   function automatic int unsigned active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > usmb_pkg::MAX_WIDTH) return usmb_pkg::MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned active_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   // advance the sharpening predictor by one word
   task automatic predict_sharpen(input pixel_word_type wd);
      int unsigned w, h, lag, r, c, ctr;
      int sum, num, res, rr, cc, g;
      sharp_word_type sw;
      w = active_width();
      h = active_height();
      lag = 2 * w + 3;
      if (fed_count < w * h)
         pix_ring[fed_count % RING] = wd.drain ? 8'd0 : wd.sample;
      fed_count++;
      if (fed_count < lag) return;
      r = next_row;
      c = next_col;
      ctr = pix_ring[(r * w + c) % RING];
      sum = 0;
      for (int dr = -2; dr <= 2; dr++) begin
         rr = int'(r) + dr;
         if (rr < 0 || rr >= int'(h)) continue;
         for (int dc = -2; dc <= 2; dc++) begin
            cc = int'(c) + dc;
            if (cc < 0 || cc >= int'(w)) continue;
            sum += pix_ring[(rr * w + cc) % RING];
         end
      end
      g = $signed(cfg_gain);
      num = usmb_pkg::SCALE * int'(ctr) + g * (usmb_pkg::AREA * int'(ctr) - sum);
      res = num / usmb_pkg::SCALE;
      if (res < 0) res = 0;
      if (res > 255) res = 255;
      sw.out_sample = res[7:0];
      sw.frame_done = (r == h - 1) && (c == w - 1);
      expected_pixels.push_back(sw);
      if (sw.frame_done) begin
         fed_count = 0; next_row = 0; next_col = 0;
      end else if (c + 1 >= w) begin
         next_col = 0; next_row = r + 1;
      end else begin
         next_col = c + 1;
      end
   endtask

   // driver: bursts and gaps, words held until accepted
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_sharpen('{req_sample, req_drain});
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !pause_req) begin
               pixel_word_type nw;
               nw = pending_words.pop_front();
               req_valid <= 1'b1;
               req_sample <= nw.sample;
               req_drain <= nw.drain;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern and result check
   int stall_mode = 0;
   int stall_cnt = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: out_sample=%0d frame_done=%0b",
                           rsp_out_sample, rsp_frame_done);
            end else begin
               sharp_word_type ew;
               ew = expected_pixels.pop_front();
               if (rsp_frame_done) frames_done++;
               if (ew.out_sample !== rsp_out_sample || ew.frame_done !== rsp_frame_done) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp out_sample=%0d frame_done=%0b, got %0d %0b",
                              ew.out_sample, ew.frame_done, rsp_out_sample,
                              rsp_frame_done);
               end
            end
         end
         stall_cnt++;
         if (stall_cnt >= 200) begin
            stall_cnt = 0;
            stall_mode = $urandom_range(0, 2);
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= (stall_cnt % 7) < 3;
         endcase
      end
   end

   // watchdog on accept-free cycles
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("unsharp_mask_5x5_box_core regression: fail");
         $finish;
      end
   end

   task automatic wait_drained();
      do begin
         while (pending_words.size() > 0 || req_valid || expected_pixels.size() > 0)
            @(posedge clock);
         // let the block finish any word that yields no result
         repeat (12) @(posedge clock);
      end while (pending_words.size() > 0 || req_valid || expected_pixels.size() > 0);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [12:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == usmb_pkg::REG_WIDTH) begin
         cfg_width = val[10:0]; fed_count = 0; next_row = 0; next_col = 0;
      end else if (idx == usmb_pkg::REG_HEIGHT) begin
         cfg_height = val; fed_count = 0; next_row = 0; next_col = 0;
      end else begin
         cfg_gain = val[11:0];
      end
   endtask

   // queue one frame of random content, optionally flat or edge-heavy, plus drain
   task automatic queue_frame(input int kind);
      int unsigned w, h;
      pixel_word_type wd;
      w = active_width();
      h = active_height();
      for (int i = 0; i < w * h; i++) begin
         case (kind)
            0: wd.sample = 8'($urandom_range(0, 255));
            1: wd.sample = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            default: wd.sample = 8'(128 + $urandom_range(0, 8));
         endcase
         wd.drain = ($urandom_range(0, 60) == 0);
         pending_words.push_back(wd);
      end
      for (int i = 0; i < 2 * w + 2; i++) begin
         wd.sample = 8'($urandom_range(0, 255));
         wd.drain = ($urandom_range(0, 7) != 0);
         pending_words.push_back(wd);
      end
   endtask

   initial begin
      int gains[6];
      int rand_frames;
      pixel_word_type wd;
      cfg_width = 640; cfg_height = 480; cfg_gain = 12'd256;
      fed_count = 0; next_row = 0; next_col = 0;
      rand_frames = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small frame with extreme pixels and extreme gains
      csr_write(usmb_pkg::REG_WIDTH, 13'd3);
      csr_write(usmb_pkg::REG_HEIGHT, 13'd3);
      csr_write(usmb_pkg::REG_GAIN, 13'h7FF);
      for (int i = 0; i < 9; i++) begin
         wd.sample = (i % 2) ? 8'd255 : 8'd0;
         wd.drain = (i == 4);
         pending_words.push_back(wd);
      end
      // extra pixels past the frame act as drain, then frame restarts
      for (int i = 0; i < 8; i++) begin
         wd.sample = 8'hFF; wd.drain = (i % 2 != 0);
         pending_words.push_back(wd);
      end
      wait_drained();
      csr_write(usmb_pkg::REG_GAIN, 13'h800);
      queue_frame(1);
      wait_drained();
      // width zero and height zero
      csr_write(usmb_pkg::REG_WIDTH, 13'd0);
      csr_write(usmb_pkg::REG_HEIGHT, 13'd0);
      csr_write(usmb_pkg::REG_GAIN, 13'd0);
      queue_frame(0);
      wait_drained();
      // wider frame with the gain field at its top code
      csr_write(usmb_pkg::REG_WIDTH, 13'd64);
      csr_write(usmb_pkg::REG_HEIGHT, 13'd2);
      csr_write(usmb_pkg::REG_GAIN, 13'h1FFF);
      queue_frame(0);
      wait_drained();

      // random frames with varied settings
      gains = '{0, 256, 2047, -2048, 64, -300};
      while (words_sent < 1500) begin
         csr_write(usmb_pkg::REG_WIDTH, 13'($urandom_range(1, 12)));
         csr_write(usmb_pkg::REG_HEIGHT, 13'($urandom_range(1, 10)));
         csr_write(usmb_pkg::REG_GAIN, ($urandom_range(0, 1) != 0) ?
                   13'(gains[$urandom_range(0, 5)]) : 13'($urandom_range(0, 8191)));
         queue_frame($urandom_range(0, 2));
         if (rand_frames == 0 || $urandom_range(0, 3) == 0) begin
            // let results queue up, then hold the sender until all are back
            while (expected_pixels.size() == 0 && pending_words.size() > 0)
               @(posedge clock);
            pause_req = 1;
            while (expected_pixels.size() > 0 || req_valid) @(posedge clock);
            pause_req = 0;
         end
         rand_frames++;
         wait_drained();
      end

      $display("covered %0d words, %0d results, %0d frames, with widths 1..64",
               words_sent, results_seen, frames_done);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("unsharp_mask_5x5_box_core regression: pass");
      else
         $display("unsharp_mask_5x5_box_core regression: fail");
      $finish;
   end

endmodule
